FILE: src/psm_pkg.sv
package psm_pkg;

  // Speed register width; reported fields keep the low FIELD_W bits.
  localparam int SPEED_BITS = 24;

  localparam int FIELD_W   = 24;
  localparam int CNT_W     = 32;
  localparam int TIME_W    = 32;
  localparam int SCALE_W   = 24;
  localparam int INTV_W    = 16;
  localparam int SUM_W     = 56;
  localparam int PROD_W    = CNT_W + SCALE_W;

  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 1;

  // Shared divider: 56-bit dividend, 32-bit divisor, two quotient bits per cycle.
  localparam int DIVD_W    = SUM_W;
  localparam int DIVS_W    = 32;
  localparam int DIV_STEPS = DIVD_W / 2;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  localparam logic [INTV_W-1:0]  MIN_INTV_RST = INTV_W'(1000);
  localparam logic [SCALE_W-1:0] SCALE_RST    = SCALE_W'(140364);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_INTERVAL = 1'b0,
    CFG_SPEED_SCALE  = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    FUNC_READING = 1'b0,
    FUNC_CLEAR   = 1'b1
  } func_e;

  typedef struct packed {
    logic load_in;
    logic clear_stats;
    logic mul_en;
    logic div_spd_start;
    logic update;
    logic div_avg_start;
    logic avg_load;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic is_clear;
    logic gate_ok;
    logic div_done;
    logic out_free;
  } dp_stat_t;

endpackage

FILE: src/psm_in_if.sv
interface psm_in_if;
  import psm_pkg::*;

  logic              valid;
  logic              ready;
  logic              func;
  logic [CNT_W-1:0]  counter_value;
  logic [TIME_W-1:0] sample_time_ms;

  modport source (output valid, func, counter_value, sample_time_ms, input ready);
  modport sink   (input valid, func, counter_value, sample_time_ms, output ready);
endinterface

FILE: src/psm_out_if.sv
interface psm_out_if;
  import psm_pkg::*;

  logic               valid;
  logic               ready;
  logic               accepted;
  logic [FIELD_W-1:0] speed_q8;
  logic [FIELD_W-1:0] average_q8;
  logic [FIELD_W-1:0] maximum_q8;

  modport source (output valid, accepted, speed_q8, average_q8, maximum_q8, input ready);
  modport sink   (input valid, accepted, speed_q8, average_q8, maximum_q8, output ready);
endinterface

FILE: src/psm_div.sv
module psm_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [psm_pkg::DIVD_W-1:0]  dividend_i,
  input  logic [psm_pkg::DIVS_W-1:0]  divisor_i,
  output logic                        done_o,
  output logic [psm_pkg::DIVD_W-1:0]  quotient_o
);
  import psm_pkg::*;

  logic                 busy_q, busy_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIVS_W-1:0]    rem_q, rem_d;
  logic [DIVS_W-1:0]    dvs_q, dvs_d;
  // dividend bits shift out at the top, quotient bits shift in at the bottom
  logic [DIVD_W-1:0]    quo_q, quo_d;

  logic [DIVS_W:0]      r1, r2, r1_sub, r2_sub;
  logic [DIVS_W-1:0]    r1_res, r2_res;
  logic                 ge1, ge2;

  // two restoring steps per cycle
  always_comb begin
    r1     = {rem_q, quo_q[DIVD_W-1]};
    r1_sub = r1 - {1'b0, dvs_q};
    ge1    = (r1 >= {1'b0, dvs_q});
    r1_res = ge1 ? r1_sub[DIVS_W-1:0] : r1[DIVS_W-1:0];
    r2     = {r1_res, quo_q[DIVD_W-2]};
    r2_sub = r2 - {1'b0, dvs_q};
    ge2    = (r2 >= {1'b0, dvs_q});
    r2_res = ge2 ? r2_sub[DIVS_W-1:0] : r2[DIVS_W-1:0];
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(DIV_STEPS);
      rem_d  = '0;
      dvs_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = r2_res;
      quo_d = {quo_q[DIVD_W-3:0], ge1, ge2};
      cnt_d = cnt_q - DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign done_o     = !busy_q;
  assign quotient_o = quo_q;

endmodule

FILE: src/psm_datapath.sv
module psm_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  psm_pkg::dp_cmd_t              cmd_i,
  output psm_pkg::dp_stat_t             stat_o,
  input  logic                          cfg_we_i,
  input  logic [psm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [psm_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          func_i,
  input  logic [psm_pkg::CNT_W-1:0]     counter_value_i,
  input  logic [psm_pkg::TIME_W-1:0]    sample_time_ms_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic                          accepted_o,
  output logic [psm_pkg::FIELD_W-1:0]   speed_q8_o,
  output logic [psm_pkg::FIELD_W-1:0]   average_q8_o,
  output logic [psm_pkg::FIELD_W-1:0]   maximum_q8_o
);
  import psm_pkg::*;

  localparam logic [SPEED_BITS-1:0] SPEED_MAX = '1;

  // configuration
  logic [INTV_W-1:0]  min_intv_q;
  logic [SCALE_W-1:0] scale_q;

  // captured word
  logic               func_q;
  logic [CNT_W-1:0]   cnt_in_q;
  logic [TIME_W-1:0]  time_in_q;
  logic [CNT_W-1:0]   dc_q;
  logic [TIME_W-1:0]  dt_q;
  logic [PROD_W-1:0]  prod_q;

  // meter state
  logic [CNT_W-1:0]      last_count_q;
  logic [TIME_W-1:0]     last_time_q;
  logic [SPEED_BITS-1:0] cur_speed_q;
  logic [SPEED_BITS-1:0] max_q;
  logic [SUM_W-1:0]      sum_q;
  logic [DIVS_W-1:0]     count_q;
  logic [FIELD_W-1:0]    avg_q;
  logic                  acc_q;

  logic                  out_valid_q;
  logic                  out_acc_q;
  logic [FIELD_W-1:0]    out_spd_q, out_avg_q, out_max_q;

  logic [INTV_W-1:0]     gate;
  logic                  div_start;
  logic [DIVD_W-1:0]     div_dividend;
  logic [DIVS_W-1:0]     div_divisor;
  logic                  div_done;
  logic [DIVD_W-1:0]     div_quo;
  logic [SPEED_BITS-1:0] spd_sat;
  logic [SUM_W:0]        sum_add;
  logic                  out_free;

  assign gate = (min_intv_q == '0) ? INTV_W'(1) : min_intv_q;

  // shared divider: speed = product / dt, average = sum / count
  assign div_start    = cmd_i.div_spd_start || cmd_i.div_avg_start;
  assign div_dividend = cmd_i.div_avg_start ? sum_q : DIVD_W'(prod_q);
  assign div_divisor  = cmd_i.div_avg_start ? count_q : DIVS_W'(dt_q);

  psm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign spd_sat = (|div_quo[DIVD_W-1:SPEED_BITS]) ? SPEED_MAX : div_quo[SPEED_BITS-1:0];
  assign sum_add = {1'b0, sum_q} + (SUM_W+1)'(spd_sat);
  assign out_free = !out_valid_q || out_ready_i;

  assign stat_o.is_clear = (func_q == FUNC_CLEAR);
  assign stat_o.gate_ok  = (dt_q >= TIME_W'(gate));
  assign stat_o.div_done = div_done;
  assign stat_o.out_free = out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_intv_q <= MIN_INTV_RST;
      scale_q    <= SCALE_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_MIN_INTERVAL) begin
        min_intv_q <= cfg_data_i[INTV_W-1:0];
      end
      if (cfg_idx_i == CFG_SPEED_SCALE) begin
        scale_q <= cfg_data_i[SCALE_W-1:0];
      end
    end
  end

  // word capture and product; deltas wrap modulo 2^32
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      func_q    <= func_i;
      cnt_in_q  <= counter_value_i;
      time_in_q <= sample_time_ms_i;
      dc_q      <= counter_value_i - last_count_q;
      dt_q      <= sample_time_ms_i - last_time_q;
    end
    if (cmd_i.mul_en) begin
      prod_q <= PROD_W'(dc_q) * PROD_W'(scale_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_count_q <= '0;
      last_time_q  <= '0;
      cur_speed_q  <= '0;
      max_q        <= '0;
      sum_q        <= '0;
      count_q      <= '0;
      avg_q        <= '0;
      acc_q        <= 1'b0;
    end else begin
      if (cmd_i.load_in) begin
        acc_q <= 1'b0;
      end
      if (cmd_i.clear_stats) begin
        max_q   <= '0;
        sum_q   <= '0;
        count_q <= '0;
        avg_q   <= '0;
      end
      if (cmd_i.update) begin
        acc_q        <= 1'b1;
        last_count_q <= cnt_in_q;
        last_time_q  <= time_in_q;
        cur_speed_q  <= spd_sat;
        if (spd_sat > max_q) begin
          max_q <= spd_sat;
        end
        sum_q <= sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
        if (count_q != {DIVS_W{1'b1}}) begin
          count_q <= count_q + DIVS_W'(1);
        end
      end
      if (cmd_i.avg_load) begin
        avg_q <= div_quo[FIELD_W-1:0];
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_acc_q <= acc_q;
      out_spd_q <= FIELD_W'(cur_speed_q);
      out_avg_q <= avg_q;
      out_max_q <= FIELD_W'(max_q);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign accepted_o   = out_acc_q;
  assign speed_q8_o   = out_spd_q;
  assign average_q8_o = out_avg_q;
  assign maximum_q8_o = out_max_q;

endmodule

FILE: src/psm_ctrl.sv
module psm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  psm_pkg::dp_stat_t stat_i,
  output psm_pkg::dp_cmd_t  cmd_o
);
  import psm_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_CHECK    = 8'b0000_0010,
    ST_MUL      = 8'b0000_0100,
    ST_SPD_GO   = 8'b0000_1000,
    ST_SPD_WAIT = 8'b0001_0000,
    ST_AVG_GO   = 8'b0010_0000,
    ST_AVG_WAIT = 8'b0100_0000,
    ST_FINISH   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_CHECK;
        end
      end
      ST_CHECK: begin
        priority if (stat_i.is_clear) begin
          cmd_o.clear_stats = 1'b1;
          state_d           = ST_FINISH;
        end else if (stat_i.gate_ok) begin
          state_d = ST_MUL;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = ST_SPD_GO;
      end
      ST_SPD_GO: begin
        cmd_o.div_spd_start = 1'b1;
        state_d             = ST_SPD_WAIT;
      end
      ST_SPD_WAIT: begin
        if (stat_i.div_done) begin
          cmd_o.update = 1'b1;
          state_d      = ST_AVG_GO;
        end
      end
      ST_AVG_GO: begin
        cmd_o.div_avg_start = 1'b1;
        state_d             = ST_AVG_WAIT;
      end
      ST_AVG_WAIT: begin
        if (stat_i.div_done) begin
          cmd_o.avg_load = 1'b1;
          state_d        = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: src/pulse_count_speed_meter.sv
// Channel   Dir  Handshake     Word
// in_i      in   valid/ready   func, counter_value[31:0], sample_time_ms[31:0]
// out_o     out  valid/ready   accepted (1b), speed_q8, average_q8, maximum_q8 (24b)
// cfg       in   cfg_we_i      cfg_idx_i (0 min_interval_ms, 1 speed_scale), cfg_data_i
//
// Accepted reading: capture, gate check, multiply, speed and average on the shared
//   radix-4 divider (each start followed by a wait for done), then output load.
// Clear command or rejected reading: capture, gate check, output load.
// Reset clears all meter state and loads the register defaults (1000 ms, 140364).
// One word at a time; a new word is taken while the last result still waits in
//   the output register, and the controller stalls only if that register is full.
module pulse_count_speed_meter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  psm_in_if.sink                        in_i,
  psm_out_if.source                     out_o,
  input  logic                          cfg_we_i,
  input  logic [psm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [psm_pkg::CFG_W-1:0]     cfg_data_i
);
  import psm_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer: capture, gate, multiply, two divisions, output
  psm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // deltas, 32x24 product, shared divider, statistics and output register
  psm_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .func_i           (in_i.func),
    .counter_value_i  (in_i.counter_value),
    .sample_time_ms_i (in_i.sample_time_ms),
    .out_ready_i      (out_o.ready),
    .out_valid_o      (out_o.valid),
    .accepted_o       (out_o.accepted),
    .speed_q8_o       (out_o.speed_q8),
    .average_q8_o     (out_o.average_q8),
    .maximum_q8_o     (out_o.maximum_q8)
  );

endmodule

FILE: tb/sv/tb_pulse_count_speed_meter.sv
`timescale 1ns / 100ps

module tb_pulse_count_speed_meter;
  import psm_pkg::*;

  // One input word: a counter reading or a clear command.
  typedef struct packed {
    func_e             func;
    logic [CNT_W-1:0]  counter_value;
    logic [TIME_W-1:0] sample_time_ms;
  } reading_t;

  // One result word, as the block reports it.
  typedef struct packed {
    logic               accepted;
    logic [FIELD_W-1:0] speed_q8;
    logic [FIELD_W-1:0] average_q8;
    logic [FIELD_W-1:0] maximum_q8;
  } speed_report_t;

  localparam logic [63:0] SUM_LIMIT   = (64'd1 << SUM_W) - 64'd1;
  localparam logic [63:0] SPEED_LIMIT = (64'd1 << SPEED_BITS) - 64'd1;
  localparam int          MAX_WAIT    = 17;
  localparam int          PHASE_WORDS = 255;
  localparam int          NUM_PHASES  = 6;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  psm_in_if  reading_bus ();
  psm_out_if report_bus ();

  pulse_count_speed_meter i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (reading_bus),
    .out_o      (report_bus),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Timeout: far beyond the slowest legal run.
  initial begin
    #12_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor: own copy of the registers and the meter state.
  // ---------------------------------------------------------------------------
  logic [INTV_W-1:0]  interval_reg;
  logic [SCALE_W-1:0] scale_reg;
  logic [CNT_W-1:0]   prev_count;
  logic [TIME_W-1:0]  prev_time;
  logic [63:0]        cur_speed;
  logic [63:0]        peak_speed;
  logic [63:0]        speed_total;
  logic [31:0]        speed_samples;

  function automatic speed_report_t compute_report(input reading_t w);
    speed_report_t     rep;
    logic [TIME_W-1:0] gate;
    logic [TIME_W-1:0] dt;
    logic [CNT_W-1:0]  dc;
    logic [63:0]       spd;
    rep.accepted = 1'b0;
    if (w.func == FUNC_CLEAR) begin
      // clear drops the statistics only; last reading and speed stay
      peak_speed    = '0;
      speed_total   = '0;
      speed_samples = '0;
    end else begin
      // an interval of zero behaves as one, so dt is never zero here
      gate = (interval_reg == '0) ? TIME_W'(1) : TIME_W'(interval_reg);
      dt   = w.sample_time_ms - prev_time;
      if (dt >= gate) begin
        dc  = w.counter_value - prev_count;
        spd = (64'(dc) * 64'(scale_reg)) / 64'(dt);
        if (spd > SPEED_LIMIT) spd = SPEED_LIMIT;
        cur_speed = spd;
        if (spd > peak_speed) peak_speed = spd;
        if (speed_total > SUM_LIMIT - spd) speed_total = SUM_LIMIT;
        else speed_total = speed_total + spd;
        if (speed_samples != '1) speed_samples = speed_samples + 32'd1;
        prev_count   = w.counter_value;
        prev_time    = w.sample_time_ms;
        rep.accepted = 1'b1;
      end
    end
    rep.speed_q8   = cur_speed[FIELD_W-1:0];
    rep.average_q8 = (speed_samples == '0) ? '0 :
                     FIELD_W'(speed_total / 64'(speed_samples));
    rep.maximum_q8 = peak_speed[FIELD_W-1:0];
    return rep;
  endfunction

  // ---------------------------------------------------------------------------
  // Queues and counters.
  // ---------------------------------------------------------------------------
  reading_t      readings_todo [$];  // words not yet offered to the block
  speed_report_t reports_due   [$];  // predicted results, oldest first
  int            mismatches;

  // Stimulus plan: last reading the block should have taken.
  logic [TIME_W-1:0] plan_time;
  logic [CNT_W-1:0]  plan_count;

  // Per-word wait, with calm stretches where nobody idles.
  function automatic int draw_wait(inout bit calm);
    if ($urandom_range(0, 39) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers words from readings_todo, predicts each one on acceptance.
  // ---------------------------------------------------------------------------
  reading_t word_on_bus;
  int       send_gap;
  bit       send_calm;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (reading_bus.valid && reading_bus.ready) begin
        reports_due.push_back(compute_report(word_on_bus));
      end
      if (!reading_bus.valid || reading_bus.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          reading_bus.valid <= 1'b0;
        end else if (readings_todo.size() > 0) begin
          word_on_bus = readings_todo.pop_front();
          reading_bus.valid          <= 1'b1;
          reading_bus.func           <= word_on_bus.func;
          reading_bus.counter_value  <= word_on_bus.counter_value;
          reading_bus.sample_time_ms <= word_on_bus.sample_time_ms;
          send_gap = draw_wait(send_calm);
        end else begin
          reading_bus.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks every result word against the oldest prediction.
  // The hold count runs only while a word waits, so each word sees its stall.
  // ---------------------------------------------------------------------------
  speed_report_t due;
  int            recv_hold;
  bit            recv_calm;

  task automatic check_field(input string name, input logic [FIELD_W-1:0] want,
                             input logic [FIELD_W-1:0] got);
    if (got !== want) begin
      $error("%s expected %0d got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (report_bus.valid && report_bus.ready) begin
        if (reports_due.size() == 0) begin
          $error("result word with no reading pending");
          mismatches++;
        end else begin
          due = reports_due.pop_front();
          check_field("accepted", FIELD_W'(due.accepted), FIELD_W'(report_bus.accepted));
          check_field("speed_q8", due.speed_q8, report_bus.speed_q8);
          check_field("average_q8", due.average_q8, report_bus.average_q8);
          check_field("maximum_q8", due.maximum_q8, report_bus.maximum_q8);
        end
        recv_hold = draw_wait(recv_calm);
      end else if (report_bus.valid && recv_hold > 0) begin
        recv_hold--;
      end
      report_bus.ready <= (recv_hold == 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  // Queue one word and follow the gate so later words can be aimed at it.
  task automatic queue_reading(input func_e f, input logic [CNT_W-1:0] cnt,
                               input logic [TIME_W-1:0] t);
    reading_t          w;
    logic [TIME_W-1:0] gate;
    logic [TIME_W-1:0] dt;
    w.func           = f;
    w.counter_value  = cnt;
    w.sample_time_ms = t;
    readings_todo.push_back(w);
    gate = (interval_reg == '0) ? TIME_W'(1) : TIME_W'(interval_reg);
    dt   = t - plan_time;
    if (f == FUNC_READING && dt >= gate) begin
      plan_time  = t;
      plan_count = cnt;
    end
  endtask

  // Registers change only with the block idle.
  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_MIN_INTERVAL) interval_reg = data[INTV_W-1:0];
    else scale_reg = data[SCALE_W-1:0];
  endtask

  // Wait until every word went in and every result came back.
  task automatic drain();
    @(negedge clk_i);
    while (readings_todo.size() != 0 || reading_bus.valid || reports_due.size() != 0)
      @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Mostly well-formed readings past the gate, plus clears, early readings
  // and fully random words.
  task automatic run_random(input int n);
    logic [TIME_W-1:0] gate;
    logic [TIME_W-1:0] t;
    logic [CNT_W-1:0]  c;
    int                pick;
    for (int k = 0; k < n; k++) begin
      gate = (interval_reg == '0) ? TIME_W'(1) : TIME_W'(interval_reg);
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        queue_reading(FUNC_CLEAR, $urandom, $urandom);
      end else if (pick < 14) begin
        queue_reading(FUNC_READING, $urandom, plan_time + $urandom_range(0, gate - 1));
      end else if (pick < 20) begin
        queue_reading(FUNC_READING, $urandom, $urandom);
      end else begin
        case ($urandom_range(0, 9))
          0:       t = plan_time + gate;
          1:       t = plan_time + gate + $urandom;
          2:       t = plan_time + gate + $urandom_range(0, 3);
          default: t = plan_time + gate + $urandom_range(0, gate);
        endcase
        case ($urandom_range(0, 7))
          0:       c = plan_count;
          1:       c = $urandom;
          2:       c = plan_count + $urandom_range(0, 15);
          default: c = plan_count + $urandom_range(0, 3000);
        endcase
        queue_reading(FUNC_READING, c, t);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni                     = 1'b0;
    reading_bus.valid          = 1'b0;
    reading_bus.func           = FUNC_READING;
    reading_bus.counter_value  = '0;
    reading_bus.sample_time_ms = '0;
    report_bus.ready           = 1'b0;
    cfg_we_i                   = 1'b0;
    cfg_idx_i                  = CFG_MIN_INTERVAL;
    cfg_data_i                 = '0;
    interval_reg               = MIN_INTV_RST;
    scale_reg                  = SCALE_RST;
    prev_count                 = '0;
    prev_time                  = '0;
    cur_speed                  = '0;
    peak_speed                 = '0;
    speed_total                = '0;
    speed_samples              = '0;
    plan_time                  = '0;
    plan_count                 = '0;
    mismatches                 = 0;
    send_gap                   = 0;
    send_calm                  = 1'b0;
    recv_hold                  = 0;
    recv_calm                  = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Register defaults after reset; first reading measured against zero.
    queue_reading(FUNC_READING, 32'd0, 32'd500);            // too early
    queue_reading(FUNC_READING, 32'd10, 32'd1000);          // exactly at the gate
    queue_reading(FUNC_READING, 32'd15, 32'd1999);          // one ms short
    queue_reading(FUNC_CLEAR, '1, '1);                      // fields ignored
    queue_reading(FUNC_READING, '1, '1);                    // huge deltas
    queue_reading(FUNC_READING, 32'd5, 32'h0000_03E7);      // both deltas wrap
    queue_reading(FUNC_READING, 32'h1000_0005, 32'h0000_07CF); // saturates
    queue_reading(FUNC_READING, 32'h1000_0005, 32'h0000_0BB7); // no pulses
    queue_reading(FUNC_CLEAR, '0, '0);
    queue_reading(FUNC_READING, 32'h1000_0105, 32'h0000_0F9F); // first after clear
    drain();

    // Zero interval acts as one ms (upper data bits fall off); largest scale.
    write_reg(CFG_MIN_INTERVAL, 24'hFF_0000);
    write_reg(CFG_SPEED_SCALE, 24'hFF_FFFF);
    queue_reading(FUNC_READING, plan_count + 32'd7, plan_time);        // dt of zero
    queue_reading(FUNC_READING, plan_count + 32'd1, plan_time + 32'd1); // top speed
    queue_reading(FUNC_READING, plan_count + 32'd2, plan_time + 32'd1); // saturates
    queue_reading(FUNC_READING, plan_count, plan_time + 32'd1);
    drain();

    // Longest interval, smallest nonzero scale.
    write_reg(CFG_MIN_INTERVAL, 24'h00_FFFF);
    write_reg(CFG_SPEED_SCALE, 24'd1);
    queue_reading(FUNC_READING, plan_count - 32'd1, plan_time + 32'h0000_FFFE);
    queue_reading(FUNC_READING, plan_count - 32'd1, plan_time + 32'h0000_FFFF);
    queue_reading(FUNC_CLEAR, $urandom, $urandom);
    drain();

    // Random phases, each under its own register setting.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin
          write_reg(CFG_MIN_INTERVAL, 24'd1000);
          write_reg(CFG_SPEED_SCALE, 24'd140364);
        end
        1: begin
          write_reg(CFG_MIN_INTERVAL, 24'd1);
          write_reg(CFG_SPEED_SCALE, 24'hFF_FFFF);
        end
        2: begin
          write_reg(CFG_MIN_INTERVAL, 24'd0);
          write_reg(CFG_SPEED_SCALE, 24'd1);
        end
        3: begin
          write_reg(CFG_MIN_INTERVAL, 24'h00_FFFF);
          write_reg(CFG_SPEED_SCALE, CFG_W'($urandom_range(1, 24'hFF_FFFF)));
        end
        4: begin
          write_reg(CFG_MIN_INTERVAL, CFG_W'($urandom_range(0, 24'hFF_FFFF)));
          write_reg(CFG_SPEED_SCALE, CFG_W'($urandom_range(1, 24'hFF_FFFF)));
        end
        default: begin
          write_reg(CFG_MIN_INTERVAL, CFG_W'($urandom_range(1, 200)));
          write_reg(CFG_SPEED_SCALE, 24'd140364);
        end
      endcase
      run_random(PHASE_WORDS);
      drain();
    end

    // Room for any stray result word to show up.
    repeat (80) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/psm_pkg.sv
src/psm_in_if.sv
src/psm_out_if.sv
src/psm_div.sv
src/psm_datapath.sv
src/psm_ctrl.sv
src/pulse_count_speed_meter.sv
tb/sv/tb_pulse_count_speed_meter.sv
